// ----- design/tsf_pkg.sv -----
// shared command and status types for the triangle scanline filler
package tsf_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture and sort a new triangle
        logic step;       // advance to the next row
        logic mul;        // register edge products
        logic start;      // form the numerator and start the divider
        logic store;      // round and store one edge x
        logic store_mid;  // the stored edge belongs to the middle-row probe
        logic sel_short;  // evaluate the short path instead of the long edge
        logic use_mid;    // evaluate at the middle row instead of the current row
        logic emit;       // load the output register with a span
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic active;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- design/tsf_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module tsf_div #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*COORD_BITS+2:0]   i_num,
    input  logic [COORD_BITS-1:0]     i_den,
    output logic                      o_done,
    output logic [COORD_BITS-1:0]     o_quo,
    output logic [COORD_BITS-1:0]     o_rem
);
    localparam int TW = 2 * COORD_BITS + 3;
    localparam int CW = $clog2(COORD_BITS);

    logic [TW-1:0]         r_rem, n_rem;
    logic [TW-1:0]         r_dsr;
    logic [COORD_BITS-1:0] r_quo;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  ge;

    // trial subtraction against the shifted divisor
    always_comb begin
        ge    = (r_rem >= r_dsr);
        n_rem = ge ? (r_rem - r_dsr) : r_rem;
    end

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(COORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder, divisor and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsr <= TW'(i_den) << (COORD_BITS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsr <= r_dsr >> 1;
            r_quo <= {r_quo[COORD_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[COORD_BITS-1:0];

endmodule

// ----- design/tsf_dp.sv -----
// datapath: vertex store, edge evaluation and span output register
module tsf_dp #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsf_pkg::t_cmd                 i_cmd,
    output tsf_pkg::t_sts                 o_sts,
    input  logic signed [COORD_BITS-1:0]  i_v0_x,
    input  logic signed [COORD_BITS-1:0]  i_v0_y,
    input  logic signed [COORD_BITS-1:0]  i_v1_x,
    input  logic signed [COORD_BITS-1:0]  i_v1_y,
    input  logic signed [COORD_BITS-1:0]  i_v2_x,
    input  logic signed [COORD_BITS-1:0]  i_v2_y,
    input  logic [COLOR_BITS-1:0]         i_fill_rgb,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_row,
    output logic signed [COORD_BITS-1:0]  o_x_start,
    output logic signed [COORD_BITS-1:0]  o_x_end,
    output logic [COLOR_BITS-1:0]         o_span_rgb,
    output logic                          o_last
);
    import tsf_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int TW = 2 * COORD_BITS + 3;

    typedef logic signed [C-1:0] t_crd;

    t_crd r_x [3];
    t_crd r_y [3];
    t_crd r_row;
    t_crd r_lx, r_sx;
    logic r_lol;
    logic r_active;
    logic [COLOR_BITS-1:0] r_color;

    // sort network on the incoming vertices
    t_crd a_x [3], a_y [3], b_x [3], b_y [3], s_x [3], s_y [3];
    always_comb begin
        a_x = '{i_v0_x, i_v1_x, i_v2_x};
        a_y = '{i_v0_y, i_v1_y, i_v2_y};
        b_x = a_x;
        b_y = a_y;
        if (a_y[1] < a_y[0]) begin
            b_x[0] = a_x[1]; b_y[0] = a_y[1];
            b_x[1] = a_x[0]; b_y[1] = a_y[0];
        end
        s_x = b_x;
        s_y = b_y;
        if (b_y[2] < b_y[0]) begin
            s_x[0] = b_x[2]; s_y[0] = b_y[2];
            s_x[2] = b_x[0]; s_y[2] = b_y[0];
        end
        b_x = s_x;
        b_y = s_y;
        if (b_y[2] < b_y[1]) begin
            s_x[1] = b_x[2]; s_y[1] = b_y[2];
            s_x[2] = b_x[1]; s_y[2] = b_y[1];
        end
    end

    // middle row and edge operand selection
    logic signed [DW-1:0] mid_diff, mid_full;
    t_crd y_ev, xa, ya, xb, yb;
    logic signed [DW-1:0] den, dx, dy;
    logic signed [2*DW-1:0] m1, m2;
    always_comb begin
        mid_diff = DW'(r_y[2]) - DW'(r_y[0]) + DW'(1);
        mid_full = DW'(r_y[0]) + (mid_diff >>> 1);
        y_ev = i_cmd.use_mid ? mid_full[C-1:0] : r_row;
        if (!i_cmd.sel_short) begin
            xa = r_x[0]; ya = r_y[0]; xb = r_x[2]; yb = r_y[2];
        end else if (y_ev < r_y[1]) begin
            xa = r_x[0]; ya = r_y[0]; xb = r_x[1]; yb = r_y[1];
        end else begin
            xa = r_x[1]; ya = r_y[1]; xb = r_x[2]; yb = r_y[2];
        end
        den = DW'(yb) - DW'(ya);
        dx  = DW'(xb) - DW'(xa);
        dy  = DW'(y_ev) - DW'(ya);
        m1  = (2*DW)'(DW'(xa)) * (2*DW)'(den);
        m2  = (2*DW)'(dx) * (2*DW)'(dy);
    end

    // product registers
    logic signed [2*DW-1:0] r_p1, r_p2;
    t_crd                   r_xa;
    logic [C-1:0]           r_den;
    logic                   r_flat;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1   <= m1;
            r_p2   <= m2;
            r_xa   <= xa;
            r_den  <= den[C-1:0];
            r_flat <= (den == '0);
        end
    end

    // numerator magnitude and sign
    logic signed [TW-1:0] t_num;
    logic [TW-1:0]        t_mag;
    logic                 r_neg;
    always_comb begin
        t_num = TW'(r_p1) + TW'(r_p2);
        t_mag = t_num[TW-1] ? TW'(-t_num) : TW'(t_num);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_neg <= t_num[TW-1];
    end

    logic         div_done;
    logic [C-1:0] quo, rem;
    tsf_div #(.COORD_BITS(COORD_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (t_mag),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    // round half away from zero
    logic         rbit;
    logic [C:0]   qr;
    logic [C:0]   qs;
    t_crd         res;
    always_comb begin
        rbit = ({rem, 1'b0} >= {1'b0, r_den});
        qr   = {1'b0, quo} + (C+1)'(rbit);
        qs   = r_neg ? (C+1)'(-qr) : qr;
        res  = r_flat ? r_xa : qs[C-1:0];
    end

    // triangle state
    logic emit_last;
    assign emit_last = (r_row >= r_y[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_active <= 1'b1;
        end else if (i_cmd.emit && emit_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= s_x;
            r_y     <= s_y;
            r_row   <= s_y[0];
            r_color <= i_fill_rgb;
        end else if (i_cmd.step) begin
            r_row <= r_row + C'(1);
        end
        if (i_cmd.store) begin
            if (!i_cmd.sel_short) r_lx <= res;
            else r_sx <= res;
            if (i_cmd.store_mid && i_cmd.sel_short) r_lol <= (r_lx < res);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_row      <= r_row;
            o_x_start  <= r_lol ? r_lx : r_sx;
            o_x_end    <= r_lol ? r_sx : r_lx;
            o_span_rgb <= r_color;
            o_last     <= emit_last;
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule

// ----- design/tsf_ctrl.sv -----
// controller state machine sequencing loads, edge evaluations and emits
module tsf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    output logic          o_in_ready,
    input  tsf_pkg::t_sts i_sts,
    output tsf_pkg::t_cmd o_cmd
);
    import tsf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_DIV  = 6'b001000,
        S_RND  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_short, n_short;
    logic   r_mid, n_mid;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_short       = r_short;
        n_mid         = r_mid;
        o_cmd         = '0;
        o_cmd.sel_short = r_short;
        o_cmd.use_mid   = r_mid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_kind) begin
                        o_cmd.load = 1'b1;
                        n_mid      = 1'b1;
                        n_short    = 1'b0;
                        n_state    = S_MUL;
                    end else if (i_sts.active) begin
                        o_cmd.step = 1'b1;
                        n_mid      = 1'b0;
                        n_short    = 1'b0;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_RND;
            end
            S_RND: begin
                o_cmd.store     = 1'b1;
                o_cmd.store_mid = r_mid;
                if (!r_short) begin
                    n_short = 1'b1;
                    n_state = S_MUL;
                end else if (r_mid) begin
                    n_mid   = 1'b0;
                    n_short = 1'b0;
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_short <= 1'b0;
            r_mid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_short <= n_short;
            r_mid   <= n_mid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- design/triangle_scanline_filler_unit.sv -----
// top level: scanline triangle filler, controller plus datapath
// each edge x is found in the states S_MUL, S_SUM, S_DIV and S_RND; a next-row transfer
// evaluates both edges at the new row, a load both at the middle row and then at the top row.
// throughput: one item at a time; input is ready again once the span is registered,
// later while the previous span still waits at the output.
// reset: synchronous active low; clears controller, output valid and active flag.
module triangle_scanline_filler_unit #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic signed [COORD_BITS-1:0]  i_v0_x,
    input  logic signed [COORD_BITS-1:0]  i_v0_y,
    input  logic signed [COORD_BITS-1:0]  i_v1_x,
    input  logic signed [COORD_BITS-1:0]  i_v1_y,
    input  logic signed [COORD_BITS-1:0]  i_v2_x,
    input  logic signed [COORD_BITS-1:0]  i_v2_y,
    input  logic [COLOR_BITS-1:0]         i_fill_rgb,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_row,
    output logic signed [COORD_BITS-1:0]  o_x_start,
    output logic signed [COORD_BITS-1:0]  o_x_end,
    output logic [COLOR_BITS-1:0]         o_span_rgb,
    output logic                          o_last
);
    import tsf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsf_dp #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_v0_x      (i_v0_x),
        .i_v0_y      (i_v0_y),
        .i_v1_x      (i_v1_x),
        .i_v1_y      (i_v1_y),
        .i_v2_x      (i_v2_x),
        .i_v2_y      (i_v2_y),
        .i_fill_rgb  (i_fill_rgb),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row       (o_row),
        .o_x_start   (o_x_start),
        .o_x_end     (o_x_end),
        .o_span_rgb  (o_span_rgb),
        .o_last      (o_last)
    );

`ifndef NO_ASSERTIONS
    // a load transfer starts edge evaluation, so input stalls next cycle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_kind) |=> !o_in_ready)
        else $error("input ready after load transfer");

    // a new span is only produced while the input side is stalled
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("span produced while idle");

    // leaving reset, no span is pending and the block takes input
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("state not cleared by reset");
`endif

endmodule

// ----- dv/testbench.sv -----
// testbench for the scanline triangle filler: directed and random triangles checked against a span predictor
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 12;
    localparam int KW = 24;
    localparam bit KIND_LOAD = 1'b0;
    localparam bit KIND_NEXT = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] row;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] xe;
        logic [KW-1:0]        rgb;
        logic                 last;
    } t_span;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_kind = 1'b0;
    logic signed [CW-1:0] i_v0_x = '0, i_v0_y = '0, i_v1_x = '0, i_v1_y = '0;
    logic signed [CW-1:0] i_v2_x = '0, i_v2_y = '0;
    logic [KW-1:0] i_fill_rgb = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [CW-1:0] o_row, o_x_start, o_x_end;
    logic [KW-1:0] o_span_rgb;
    logic o_last;

    triangle_scanline_filler_unit #(.COORD_BITS(CW), .COLOR_BITS(KW)) u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint sx[3], sy[3], cur_row;
    bit long_left, tri_active;
    logic [KW-1:0] tri_rgb;
    t_span spans_due[$];
    int failures = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic longint edge_at(longint xa, longint ya, longint xb, longint yb,
                                       longint y);
        longint den, t;
        den = yb - ya;
        if (den <= 0) return xa;
        t = xa * den + (xb - xa) * (y - ya);
        if (t >= 0) return (2 * t + den) / (2 * den);
        return -((-2 * t + den) / (2 * den));
    endfunction

    function automatic longint long_x(longint y);
        return edge_at(sx[0], sy[0], sx[2], sy[2], y);
    endfunction

    function automatic longint short_x(longint y);
        if (y < sy[1]) return edge_at(sx[0], sy[0], sx[1], sy[1], y);
        return edge_at(sx[1], sy[1], sx[2], sy[2], y);
    endfunction

    function automatic void swap_pts(int a, int b);
        longint tx, ty;
        tx = sx[a]; ty = sy[a];
        sx[a] = sx[b]; sy[a] = sy[b];
        sx[b] = tx; sy[b] = ty;
    endfunction

    function automatic void push_span();
        t_span s;
        longint lx, shx;
        lx = long_x(cur_row);
        shx = short_x(cur_row);
        s.row = cur_row[CW-1:0];
        s.xs = long_left ? lx[CW-1:0] : shx[CW-1:0];
        s.xe = long_left ? shx[CW-1:0] : lx[CW-1:0];
        s.rgb = tri_rgb;
        s.last = (cur_row >= sy[2]);
        if (s.last) tri_active = 1'b0;
        spans_due.push_back(s);
    endfunction

    // expected span for one accepted item
    function automatic void predict_span(bit kind, logic signed [CW-1:0] ax, ay, bx, by,
                                         cx, cy, logic [KW-1:0] rgb);
        longint mid;
        if (kind == KIND_NEXT) begin
            if (!tri_active) return;
            cur_row++;
            push_span();
            return;
        end
        sx[0] = longint'(ax); sy[0] = longint'(ay);
        sx[1] = longint'(bx); sy[1] = longint'(by);
        sx[2] = longint'(cx); sy[2] = longint'(cy);
        tri_rgb = rgb;
        if (sy[1] < sy[0]) swap_pts(0, 1);
        if (sy[2] < sy[0]) swap_pts(0, 2);
        if (sy[2] < sy[1]) swap_pts(1, 2);
        mid = sy[0] + (sy[2] - sy[0] + 1) / 2;
        long_left = long_x(mid) < short_x(mid);
        cur_row = sy[0];
        tri_active = 1'b1;
        push_span();
    endfunction

    // send one item, with random idle before it; valid drops only while idling
    task automatic send_item(bit kind, logic signed [CW-1:0] ax, ay, bx, by, cx, cy,
                             logic [KW-1:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_v0_x <= ax; i_v0_y <= ay; i_v1_x <= bx; i_v1_y <= by;
        i_v2_x <= cx; i_v2_y <= cy; i_fill_rgb <= rgb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_span(kind, ax, ay, bx, by, cx, cy, rgb);
    endtask

    task automatic send_tri(int ax, ay, bx, by, cx, cy, logic [KW-1:0] rgb);
        send_item(KIND_LOAD, CW'(ax), CW'(ay), CW'(bx), CW'(by), CW'(cx), CW'(cy), rgb);
    endtask

    task automatic send_next();
        send_item(KIND_NEXT, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom), CW'($urandom), KW'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (spans_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // receiver stall
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // compare each span transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_span e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (spans_due.size() == 0) begin
                $error("unexpected span row %0d", o_row);
                failures++;
            end else begin
                e = spans_due.pop_front();
                if (o_row !== e.row) begin
                    $error("row exp %0d got %0d", e.row, o_row); failures++;
                end
                if (o_x_start !== e.xs) begin
                    $error("x_start exp %0d got %0d", e.xs, o_x_start); failures++;
                end
                if (o_x_end !== e.xe) begin
                    $error("x_end exp %0d got %0d", e.xe, o_x_end); failures++;
                end
                if (o_span_rgb !== e.rgb) begin
                    $error("span_rgb exp %h got %h", e.rgb, o_span_rgb); failures++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_last); failures++;
                end
            end
        end
    end

    task automatic test_directed();
        // next row with no triangle loaded
        send_next();
        send_next();
        // flat triangle
        send_tri(-5, 7, 10, 7, 3, 7, 24'hFFFFFF);
        send_next();
        // small triangle walked to the end, then past it
        send_tri(0, 0, 6, 3, -4, 6, 24'h123456);
        repeat (7) send_next();
        // extreme coordinates, tall slivers
        send_tri(-2048, -2048, 2047, 2047, -2048, 2047, 24'h000000);
        repeat (3) send_next();
        send_tri(2047, 2047, -2048, -2048, 2047, -2047, 24'hA5A5A5);
        send_next();
        // reload in the middle of a triangle; tie at the middle row
        send_tri(0, 0, 0, 4, 0, 2, 24'h5A5A5A);
        send_next();
        // inverted span
        send_tri(10, 0, -10, 1, 20, 2, 24'h800001);
        send_next(); send_next();
        drain();
    endtask

    // mostly whole small triangles, with reloads and stray next-row items
    task automatic test_random(int n_items);
        int cnt, rows, base_x, base_y, spread;
        cnt = 0;
        while (cnt < n_items) begin
            spread = ($urandom_range(9) == 0) ? 2047 : 12;
            base_x = $signed($urandom_range(4095)) - 2048;
            base_y = $signed($urandom_range(4095)) - 2048;
            if ($urandom_range(19) == 0) begin
                send_tri($signed($urandom_range(4095)) - 2048,
                         $signed($urandom_range(4095)) - 2048,
                         $signed($urandom_range(4095)) - 2048,
                         $signed($urandom_range(4095)) - 2048,
                         $signed($urandom_range(4095)) - 2048,
                         $signed($urandom_range(4095)) - 2048, KW'($urandom));
                rows = $urandom_range(3);
            end else begin
                send_tri(base_x, base_y,
                         base_x + $signed($urandom_range(2 * spread)) - spread,
                         base_y + $signed($urandom_range(spread)),
                         base_x + $signed($urandom_range(2 * spread)) - spread,
                         base_y + $signed($urandom_range(spread)), KW'($urandom));
                rows = (spread > 12) ? $urandom_range(3) : $urandom_range(14);
            end
            cnt++;
            repeat (rows) begin
                send_next();
                cnt++;
            end
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_items);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(n_items);
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        run_phase(0, 0, 500);
        run_phase(87, 0, 350);
        run_phase(0, 87, 350);
        run_phase(22, 22, 500);
        if (failures == 0 && spans_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
